// ===== rtl/bsl_pkg.sv =====
// Shared types, character codes and keywords for the BibTeX style lexer.
`default_nettype none

package bsl_pkg;

    // Window depth default and result queue depth (power of two)
    localparam int unsigned LOOKAHEAD_DEF = 10;
    localparam int unsigned QDEPTH        = 8;
    localparam int unsigned QPTR_W        = 3;

    // Configuration register indexes
    localparam logic CFG_START_STATE = 1'b0;
    localparam logic CFG_FIRST_POS   = 1'b1;

    // Lexer states, numbered as the output styles
    typedef enum logic [3:0] {
        ST_TEXT    = 4'd0,
        ST_COMMAND = 4'd1,
        ST_TAG     = 4'd2,
        ST_MATH    = 4'd3,
        ST_COMMENT = 4'd4,
        ST_TYPE    = 4'd5,
        ST_OPEN    = 4'd6,
        ST_CLOSE   = 4'd7,
        ST_KEY     = 4'd8
    } lex_state_t;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UPPA   = 8'h41;
    localparam logic [7:0] CH_UPPZ   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_ACUTE  = 8'hB4;

    // Keywords, right-aligned, first character in the highest used byte
    localparam logic [63:0] W_BEGIN    = 64'h0000_0062_6567_696E;
    localparam logic [63:0] W_END      = 64'h0000_0000_0065_6E64;
    localparam logic [63:0] W_STRING   = 64'h0000_7374_7269_6E67;
    localparam logic [63:0] W_PREAMBLE = 64'h7072_6561_6D62_6C65;
    localparam logic [63:0] W_COMMENT  = 64'h0063_6F6D_6D65_6E74;

    // One input word
    typedef struct packed {
        logic [7:0] text_byte;
        logic       lead_byte;
        logic       doc_end;
    } in_t;

    // One result word
    typedef struct packed {
        logic [31:0] end_pos;
        logic [3:0]  style;
        logic        run_last;
    } out_t;

    // Queue writes from the front: up to three words a cycle, in order
    typedef struct packed {
        logic [1:0]       cnt;
        out_t [2:0]       w;
    } wr_t;

endpackage

`default_nettype wire

// ===== rtl/bibtex_style_lexer.sv =====
// Top level of the BibTeX style lexer: configuration, lexer front, result queue.
// A byte that fills the window is classified in its accept cycle; its results are
// then written to the queue, unless the newest is held back for run_last grouping.
// Throughput: one byte per cycle while the queue has room; a doc_end byte then
// blocks input while up to LOOKAHEAD-1 window bytes and the closing run drain.
// Reset: asynchronous, active low; clears the window, position, lexer and queue.
`default_nettype none

module bibtex_style_lexer
#(
    parameter int unsigned LOOKAHEAD = bsl_pkg::LOOKAHEAD_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire bsl_pkg::in_t  in_data,
    output logic               empty,
    input  wire logic          pop,
    output bsl_pkg::out_t      out_data,
    input  wire logic          cfg_en,
    input  wire logic          cfg_addr,
    input  wire logic [31:0]   cfg_data
);

    logic [3:0]    start_reg;
    logic [31:0]   fcp_reg;
    logic          space;
    bsl_pkg::wr_t  wr;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            fcp_reg   <= '0;
        end
        else if (cfg_en)
        begin
            unique case (cfg_addr)
                bsl_pkg::CFG_START_STATE: start_reg <= cfg_data[3:0];
                bsl_pkg::CFG_FIRST_POS:   fcp_reg   <= cfg_data;
                default:                  fcp_reg   <= fcp_reg;
            endcase
        end
    end

    bsl_front #(.LOOKAHEAD(LOOKAHEAD)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_data     (in_data),
        .start_state (start_reg),
        .first_pos   (fcp_reg),
        .space       (space),
        .wr          (wr)
    );

    bsl_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .space    (space),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    // Input must stall whenever the queue cannot take a full group of words
    a_stall_on_no_space: assert property (@(posedge clk) disable iff (!rst_n)
        !space |-> full)
        else $error("input accepted without queue room");

    // Queue drains only through a pop
    a_empty_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("queue emptied without pop");

    // Queue fills only through a front write
    a_fill_by_write: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(wr.cnt != 2'd0))
        else $error("queue filled without write");

endmodule

`default_nettype wire

// ===== rtl/bsl_queue.sv =====
// Result queue between the lexer front and the result port.
`default_nettype none

module bsl_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bsl_pkg::wr_t  wr,
    output logic               space,
    output logic               empty,
    input  wire logic          pop,
    output bsl_pkg::out_t      out_data
);

    localparam int unsigned PW = bsl_pkg::QPTR_W;

    bsl_pkg::out_t     mem [bsl_pkg::QDEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       cnt_reg, cnt_next;
    logic              do_pop;

    // Status and head word
    assign empty    = (cnt_reg == '0);
    assign space    = (cnt_reg <= (PW+1)'(bsl_pkg::QDEPTH - 3));
    assign out_data = mem[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(wr.cnt);
        rd_ptr_next = rd_ptr_reg + PW'(do_pop);
        cnt_next    = cnt_reg + (PW+1)'(wr.cnt) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store incoming words
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < wr.cnt)
                mem[wr_ptr_reg + PW'(k)] <= wr.w[k];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bsl_front.sv =====
// Lexer front: lookahead window, byte classifier and result word grouping.
`default_nettype none

module bsl_front
#(
    parameter int unsigned LOOKAHEAD = bsl_pkg::LOOKAHEAD_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire bsl_pkg::in_t  in_data,
    input  wire logic [3:0]    start_state,
    input  wire logic [31:0]   first_pos,
    input  wire logic          space,
    output bsl_pkg::wr_t       wr
);

    localparam int unsigned FW = $clog2(LOOKAHEAD + 1);
    localparam int unsigned IW = $clog2(LOOKAHEAD);

    // Keyword compare on window bytes 1..9
    function automatic logic word_is(logic [71:0] s, logic [63:0] w,
                                     int unsigned len, int unsigned limit, logic fold);
        logic       ok;
        logic [7:0] a;
        logic [7:0] t;
        ok = 1'b1;
        for (int j = 0; j < 8; j++)
        begin
            if (j < len)
            begin
                a = s[8*j +: 8];
                if (fold && a >= bsl_pkg::CH_UPPA && a <= bsl_pkg::CH_UPPZ)
                    a = a + 8'd32;
                if (a != w[8*(len-1-j) +: 8])
                    ok = 1'b0;
            end
        end
        t = s[8*len +: 8];
        if (limit != len && t != bsl_pkg::CH_LBRACE && t != bsl_pkg::CH_NUL)
            ok = 1'b0;
        return ok;
    endfunction

    function automatic logic is_special(logic [7:0] c);
        return c == bsl_pkg::CH_BSLASH || c == bsl_pkg::CH_COMMA || c == bsl_pkg::CH_SEMI
            || c == bsl_pkg::CH_QUOTE || c == bsl_pkg::CH_SPACE || c == bsl_pkg::CH_DQUOTE
            || c == bsl_pkg::CH_BTICK || c == bsl_pkg::CH_CARET || c == bsl_pkg::CH_TILDE;
    endfunction

    bsl_pkg::lex_state_t lex_reg, lex_next, b_lex, c_lex;
    logic [15:0]         depth_reg, depth_next, b_depth, c_depth;
    logic                eopen_reg, eopen_next, b_eopen, c_eopen;
    logic                plain_reg, plain_next, b_plain, c_plain;
    logic [8:0]          win_reg [LOOKAHEAD];
    logic [8:0]          win_next [LOOKAHEAD];
    logic [8:0]          wa [LOOKAHEAD];
    logic [8:0]          wn [LOOKAHEAD];
    logic [FW-1:0]       fill_reg, fill_next, b_fill, fa;
    logic [31:0]         pos_reg, pos_next, b_pos, pos_after;
    logic                in_doc_reg, in_doc_next;
    logic                drain_reg, drain_next;
    logic [32:0]         cursor_reg, cursor_next;
    logic [32:0]         last_reg, last_next;
    logic                pend_vld_reg, pend_vld_next;
    bsl_pkg::out_t       pend_reg, pend_next;

    logic                push_acc, drain_step, step, do_cls, fin, item_end;
    logic [7:0]          pk [LOOKAHEAD];
    logic [71:0]         s1;
    logic [7:0]          ch, cn;
    logic [33:0]         i34, im1, ip1;
    logic [1:0]          used;
    logic                drop2;
    logic [FW-1:0]       fill_after;
    logic                e0v, e1v, e0ok, e1ok, efok;
    logic [33:0]         e0e, e1e;
    bsl_pkg::lex_state_t e0s, e1s;
    bsl_pkg::out_t       c [3];
    logic [1:0]          nc;

    // Handshake
    assign full       = drain_reg || !space;
    assign push_acc   = push && !full;
    assign drain_step = drain_reg && space;
    assign step       = push_acc || drain_step;

    // Pick working state: fresh document or running one, then append
    always_comb
    begin
        if (in_doc_reg)
        begin
            b_lex   = lex_reg;
            b_depth = depth_reg;
            b_eopen = eopen_reg;
            b_plain = plain_reg;
            b_fill  = fill_reg;
            b_pos   = pos_reg;
        end
        else
        begin
            b_lex   = (start_state > 4'd8) ? bsl_pkg::ST_TEXT
                                           : bsl_pkg::lex_state_t'(start_state);
            b_depth = '0;
            b_eopen = 1'b0;
            b_plain = 1'b0;
            b_fill  = '0;
            b_pos   = '0;
        end
        wa = win_reg;
        if (push_acc && b_fill < FW'(LOOKAHEAD))
            wa[b_fill[IW-1:0]] = {in_data.lead_byte, in_data.text_byte};
        fa = b_fill + FW'(push_acc);
        for (int k = 0; k < LOOKAHEAD; k++)
            pk[k] = (FW'(k) < fa) ? wa[k][7:0] : bsl_pkg::CH_NUL;
        for (int k = 0; k < 9; k++)
            s1[8*k +: 8] = pk[k+1];
        ch = pk[0];
        cn = (fa > FW'(1)) ? wa[1][7:0] : bsl_pkg::CH_SPACE;
    end

    assign do_cls = (push_acc && fa == FW'(LOOKAHEAD)) || (drain_step && fill_reg != '0);
    assign fin    = drain_step && fill_reg == '0;

    // Classify the head byte
    always_comb
    begin
        i34     = {2'b00, b_pos};
        im1     = i34 - 34'd1;
        ip1     = i34 + 34'd1;
        c_lex   = b_lex;
        c_depth = b_depth;
        c_eopen = b_eopen;
        c_plain = b_plain;
        used    = 2'd1;
        e0v     = 1'b0;
        e0e     = i34;
        e0s     = bsl_pkg::ST_TEXT;
        e1v     = 1'b0;
        e1e     = ip1;
        e1s     = bsl_pkg::ST_COMMAND;
        if (wa[0][8])
            used = 2'd2;
        else
        begin
            unique case (b_lex)
                bsl_pkg::ST_TEXT:
                begin
                    if (ch == bsl_pkg::CH_BSLASH)
                    begin
                        e0v = 1'b1;
                        e0e = im1;
                        if (is_special(pk[1]))
                        begin
                            e1v  = 1'b1;
                            used = 2'd2;
                        end
                        else if (word_is(s1, bsl_pkg::W_BEGIN, 5, 5, 1'b0)
                                 || word_is(s1, bsl_pkg::W_END, 3, 5, 1'b0))
                            c_lex = bsl_pkg::ST_TAG;
                        else
                            c_lex = bsl_pkg::ST_COMMAND;
                    end
                    else if (ch == bsl_pkg::CH_AT)
                    begin
                        e0v = 1'b1;
                        e0e = im1;
                        if (b_depth == '0)
                        begin
                            c_lex   = bsl_pkg::ST_TYPE;
                            c_plain = word_is(s1, bsl_pkg::W_STRING, 6, 8, 1'b1)
                                   || word_is(s1, bsl_pkg::W_PREAMBLE, 8, 8, 1'b1)
                                   || word_is(s1, bsl_pkg::W_COMMENT, 7, 8, 1'b1);
                            c_eopen = 1'b1;
                        end
                    end
                    else if (ch == bsl_pkg::CH_LBRACE)
                        c_depth = b_depth + 16'd1;
                    else if (ch == bsl_pkg::CH_RBRACE)
                    begin
                        if (b_depth != '0)
                        begin
                            c_depth = b_depth - 16'd1;
                            if (b_depth == 16'd1 && b_eopen)
                            begin
                                e0v   = 1'b1;
                                e0e   = im1;
                                c_lex = bsl_pkg::ST_CLOSE;
                            end
                        end
                    end
                    else if (ch == bsl_pkg::CH_DOLLAR)
                    begin
                        e0v   = 1'b1;
                        e0e   = im1;
                        c_lex = bsl_pkg::ST_MATH;
                        if (cn == bsl_pkg::CH_DOLLAR)
                            used = 2'd2;
                    end
                    else if (ch == bsl_pkg::CH_PCT)
                    begin
                        e0v   = 1'b1;
                        e0e   = im1;
                        c_lex = bsl_pkg::ST_COMMENT;
                    end
                end
                bsl_pkg::ST_COMMAND:
                begin
                    if (cn == bsl_pkg::CH_LBRACK || cn == bsl_pkg::CH_LBRACE
                        || cn == bsl_pkg::CH_RBRACE || cn == bsl_pkg::CH_SPACE
                        || cn == bsl_pkg::CH_CR || cn == bsl_pkg::CH_LF
                        || cn == bsl_pkg::CH_BTICK || cn == bsl_pkg::CH_ACUTE
                        || cn == bsl_pkg::CH_QUOTE || cn == bsl_pkg::CH_DQUOTE
                        || cn == bsl_pkg::CH_EQ)
                    begin
                        e0v   = 1'b1;
                        e0s   = bsl_pkg::ST_COMMAND;
                        c_lex = bsl_pkg::ST_TEXT;
                    end
                end
                bsl_pkg::ST_TAG:
                begin
                    if (ch == bsl_pkg::CH_RBRACE)
                    begin
                        if (b_depth != '0)
                            c_depth = b_depth - 16'd1;
                        e0v   = 1'b1;
                        e0s   = bsl_pkg::ST_TAG;
                        c_lex = bsl_pkg::ST_TEXT;
                    end
                end
                bsl_pkg::ST_MATH:
                begin
                    if (ch == bsl_pkg::CH_DOLLAR)
                    begin
                        c_lex = bsl_pkg::ST_TEXT;
                        e0v   = 1'b1;
                        e0s   = bsl_pkg::ST_MATH;
                        if (cn == bsl_pkg::CH_DOLLAR)
                        begin
                            e0e  = ip1;
                            used = 2'd2;
                        end
                    end
                end
                bsl_pkg::ST_COMMENT:
                begin
                    if (ch == bsl_pkg::CH_CR || ch == bsl_pkg::CH_LF)
                    begin
                        e0v   = 1'b1;
                        e0e   = im1;
                        e0s   = bsl_pkg::ST_COMMENT;
                        c_lex = bsl_pkg::ST_TEXT;
                    end
                end
                bsl_pkg::ST_TYPE:
                begin
                    if (cn == bsl_pkg::CH_LBRACE)
                    begin
                        e0v   = 1'b1;
                        e0s   = bsl_pkg::ST_TYPE;
                        c_lex = bsl_pkg::ST_OPEN;
                    end
                end
                bsl_pkg::ST_OPEN, bsl_pkg::ST_CLOSE:
                begin
                    e0v   = b_eopen;
                    e0s   = b_lex;
                    c_lex = (b_lex == bsl_pkg::ST_OPEN && !b_plain) ? bsl_pkg::ST_KEY
                                                                    : bsl_pkg::ST_TEXT;
                    if (ch == bsl_pkg::CH_LBRACE)
                        c_depth = b_depth + 16'd1;
                    else if (ch == bsl_pkg::CH_RBRACE)
                    begin
                        c_depth = b_depth - 16'd1;
                        c_eopen = 1'b0;
                    end
                end
                bsl_pkg::ST_KEY:
                begin
                    if (ch == bsl_pkg::CH_COMMA || ch == bsl_pkg::CH_RBRACE)
                    begin
                        e0v   = b_eopen;
                        e0e   = im1;
                        e0s   = bsl_pkg::ST_KEY;
                        c_lex = bsl_pkg::ST_TEXT;
                    end
                end
                default:
                begin
                    c_lex = b_lex;
                end
            endcase
        end
    end

    // Drop reported runs that end below zero or below the first coloured position
    assign e0ok = do_cls && e0v && !e0e[33] && (e0e[32:0] >= {1'b0, first_pos});
    assign e1ok = do_cls && e1v && !e1e[33] && (e1e[32:0] >= {1'b0, first_pos});
    assign efok = fin && (cursor_reg >= {1'b0, first_pos})
                      && (last_reg >= {1'b0, first_pos});

    // Shift the window by one or two bytes
    always_comb
    begin
        drop2 = (used == 2'd2) && (fa >= FW'(2));
        for (int k = 0; k < LOOKAHEAD; k++)
        begin
            if (drop2)
                wn[k] = (k + 2 < LOOKAHEAD) ? wa[(k + 2) % LOOKAHEAD] : '0;
            else
                wn[k] = (k + 1 < LOOKAHEAD) ? wa[(k + 1) % LOOKAHEAD] : '0;
        end
        fill_after = do_cls ? (fa - (drop2 ? FW'(2) : FW'(1))) : fa;
        pos_after  = do_cls ? (b_pos + 32'(used)) : b_pos;
    end

    // Next state of the lexer
    always_comb
    begin
        lex_next    = lex_reg;
        depth_next  = depth_reg;
        eopen_next  = eopen_reg;
        plain_next  = plain_reg;
        win_next    = win_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        in_doc_next = in_doc_reg;
        drain_next  = drain_reg;
        cursor_next = cursor_reg;
        last_next   = last_reg;
        if (step)
        begin
            lex_next   = do_cls ? c_lex : b_lex;
            depth_next = do_cls ? c_depth : b_depth;
            eopen_next = do_cls ? c_eopen : b_eopen;
            plain_next = do_cls ? c_plain : b_plain;
            win_next   = do_cls ? wn : wa;
            fill_next  = fill_after;
            pos_next   = pos_after;
            if (push_acc)
                in_doc_next = 1'b1;
            if (push_acc && in_data.doc_end)
            begin
                drain_next  = 1'b1;
                cursor_next = {1'b0, pos_after};
                last_next   = {1'b0, pos_after} + 33'(fill_after) - 33'd1;
            end
            else if (drain_step && do_cls)
                cursor_next = cursor_reg + 33'(used);
            if (fin)
            begin
                drain_next  = 1'b0;
                in_doc_next = 1'b0;
            end
        end
    end

    assign item_end = (push_acc && !in_data.doc_end) || fin;

    // Group result words; hold the newest back until the item is known to end
    always_comb
    begin
        c             = '{default: '0};
        nc            = '0;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        wr            = '0;
        if (pend_vld_reg)
        begin
            c[nc] = pend_reg;
            nc    = nc + 2'd1;
        end
        if (e0ok)
        begin
            c[nc] = '{end_pos: e0e[31:0], style: e0s, run_last: 1'b0};
            nc    = nc + 2'd1;
        end
        if (e1ok)
        begin
            c[nc] = '{end_pos: e1e[31:0], style: e1s, run_last: 1'b0};
            nc    = nc + 2'd1;
        end
        if (efok)
        begin
            c[nc] = '{end_pos: last_reg[31:0], style: lex_reg, run_last: 1'b0};
            nc    = nc + 2'd1;
        end
        if (step && item_end)
        begin
            if (nc != '0)
                c[nc - 2'd1].run_last = 1'b1;
            wr.cnt        = nc;
            pend_vld_next = 1'b0;
        end
        else if (step && nc != '0)
        begin
            wr.cnt        = nc - 2'd1;
            pend_next     = c[nc - 2'd1];
            pend_vld_next = 1'b1;
        end
        for (int k = 0; k < 3; k++)
            wr.w[k] = c[k];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_reg      <= bsl_pkg::ST_TEXT;
            depth_reg    <= '0;
            eopen_reg    <= 1'b0;
            plain_reg    <= 1'b0;
            fill_reg     <= '0;
            pos_reg      <= '0;
            in_doc_reg   <= 1'b0;
            drain_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            lex_reg      <= lex_next;
            depth_reg    <= depth_next;
            eopen_reg    <= eopen_next;
            plain_reg    <= plain_next;
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            in_doc_reg   <= in_doc_next;
            drain_reg    <= drain_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        cursor_reg <= cursor_next;
        last_reg   <= last_next;
        pend_reg   <= pend_next;
    end

endmodule

`default_nettype wire
